/* rtl/tlvp_pkg.sv */
// Package for the interface identification TLV parser.
// Holds shared codes, the front-to-back command layout and fixed constants.
// No dependencies.
package tlvp_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_DASH       = 8'h2D;
   localparam logic [7:0] PRINT_LO        = 8'h20;
   localparam logic [7:0] PRINT_HI        = 8'h7E;

   typedef enum logic [2:0] {
      K_INDEX    = 3'd0,
      K_CHAR     = 3'd1,
      K_NAME_END = 3'd2,
      K_IPV4     = 3'd3,
      K_OK       = 3'd4,
      K_ERROR    = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_EXT_SHORT = 3'd1,
      ERR_PAST_END  = 3'd2,
      ERR_INDEX_LEN = 3'd3,
      ERR_BAD_CHAR  = 3'd4,
      ERR_ADDR_LEN  = 3'd5,
      ERR_EMPTY     = 3'd6,
      ERR_NAME_LONG = 3'd7
   } err_type;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_DATA   = 2'd1,
      PH_DROP   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      SEL_SKIP  = 2'd0,
      SEL_INDEX = 2'd1,
      SEL_NAME  = 2'd2,
      SEL_ADDR  = 2'd3
   } sel_type;

   typedef enum logic [1:0] {
      CSR_IFACE_CLASS = 2'd0,
      CSR_INDEX_TYPE  = 2'd1,
      CSR_NAME_TYPE   = 2'd2,
      CSR_ADDR_TYPE   = 2'd3
   } csr_idx_type;

   typedef enum logic [2:0] {
      B_IDLE     = 3'd0,
      B_EXT      = 3'd1,
      B_FETCH    = 3'd2,
      B_CHAR     = 3'd3,
      B_NAME_END = 3'd4,
      B_TAIL     = 3'd5
   } back_state_type;

   // One command per input byte that causes results.
   typedef struct packed {
      logic        has_ext;
      kind_type    ext_kind;
      logic [31:0] ext_value;
      logic        has_tail;
      kind_type    tail_kind;
      logic [15:0] tail_value;
      err_type     tail_code;
   } cmd_type;

   typedef struct packed {
      logic fifo_full;
      logic fifo_empty;
      logic back_busy;
   } drain_stat_type;

endpackage

/* rtl/tlvp_if.sv */
// Handshake channel interfaces of the TLV parser: input bytes, results, register writes.
// Depends on tlvp_pkg.
interface tlvp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_payload;
   modport source (output valid, output data_byte, output end_of_payload, input ready);
   modport sink (input valid, input data_byte, input end_of_payload, output ready);
endinterface

interface tlvp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [31:0] value;
   logic [2:0]  error_code;
   logic        last_of_run;
   modport source (output valid, output kind, output value, output error_code,
                   output last_of_run, input ready);
   modport sink (input valid, input kind, input value, input error_code,
                 input last_of_run, output ready);
endinterface

interface tlvp_csr_if;
   import tlvp_pkg::*;
   logic        valid;
   logic        ready;
   csr_idx_type index;
   logic [15:0] wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

/* rtl/tlvp_front.sv */
// Front of the TLV parser: takes bytes, tracks headers and data, holds the registers.
// Emits one command per result-causing byte. Depends on tlvp_pkg and tlvp_if.
module tlvp_front #(
   parameter int HEADER_BYTES  = 6,
   parameter int NAME_CAPACITY = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   tlvp_req_if.sink                         req_ch,
   tlvp_csr_if.sink                         csr_ch,
   input  tlvp_pkg::drain_stat_type         drain_stat,
   output logic                             cmd_push,
   output tlvp_pkg::cmd_type                cmd,
   output logic                             name_wr_en,
   output logic [$clog2(NAME_CAPACITY)-1:0] name_wr_addr,
   output logic [7:0]                       name_wr_data
);
   import tlvp_pkg::*;

   localparam int HPW = $clog2(HEADER_BYTES);
   localparam int NCW = $clog2(NAME_CAPACITY);

   logic [15:0] iface_class_ff;
   logic [7:0]  index_type_ff, name_type_ff, addr_type_ff;

   phase_type   phase_ff, phase_in;
   logic [HPW-1:0] hpos_ff, hpos_in;
   logic [15:0] cls_ff, cls_in, len_ff, len_in, dpos_ff, dpos_in, ecnt_ff, ecnt_in;
   logic [7:0]  typ_ff, typ_in;
   logic [31:0] acc_ff, acc_in;
   logic [NCW-1:0] ncnt_ff, ncnt_in;
   logic        nbad_ff, nbad_in;

   logic        accept, eop, cmplt;
   logic [7:0]  b;
   logic [15:0] dlen;
   err_type     err;
   sel_type     sel_cur, sel_new;
   cmd_type     cmd_c;

   function automatic sel_type select_of(logic [15:0] c, logic [7:0] t, logic [15:0] ic,
                                         logic [7:0] it, logic [7:0] nt, logic [7:0] at);
      sel_type s;
      s = SEL_SKIP;
      if (c == ic) begin
         if (t == it) s = SEL_INDEX;
         else if (t == nt) s = SEL_NAME;
         else if (t == at) s = SEL_ADDR;
      end
      return s;
   endfunction

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         iface_class_ff <= '0;
         index_type_ff  <= 8'd1;
         name_type_ff   <= 8'd2;
         addr_type_ff   <= 8'd3;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_IFACE_CLASS: iface_class_ff <= csr_ch.wdata;
            CSR_INDEX_TYPE:  index_type_ff  <= csr_ch.wdata[7:0];
            CSR_NAME_TYPE:   name_type_ff   <= csr_ch.wdata[7:0];
            CSR_ADDR_TYPE:   addr_type_ff   <= csr_ch.wdata[7:0];
            default: ;
         endcase
      end
   end

   assign sel_cur = select_of(cls_ff, typ_ff, iface_class_ff, index_type_ff,
                              name_type_ff, addr_type_ff);

   // Name bytes may only land in the store while the back is not reading it.
   assign req_ch.ready = !drain_stat.fifo_full &&
                         !(phase_ff == PH_DATA && sel_cur == SEL_NAME &&
                           (!drain_stat.fifo_empty || drain_stat.back_busy));

   assign accept = req_ch.valid && req_ch.ready;
   assign b      = req_ch.data_byte;
   assign eop    = req_ch.end_of_payload;

   always_comb begin
      phase_in = phase_ff;
      hpos_in  = hpos_ff;
      cls_in   = cls_ff;
      typ_in   = typ_ff;
      len_in   = len_ff;
      dpos_in  = dpos_ff;
      acc_in   = acc_ff;
      ncnt_in  = ncnt_ff;
      nbad_in  = nbad_ff;
      ecnt_in  = ecnt_ff;
      err      = ERR_NONE;
      cmplt    = 1'b0;
      cmd_c    = '0;
      name_wr_en   = 1'b0;
      name_wr_addr = ncnt_ff;
      name_wr_data = (b == CHAR_UNDERSCORE) ? CHAR_DASH : b;
      sel_new  = SEL_SKIP;
      dlen     = '0;
      if (accept) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (hpos_ff == HPW'(0)) cls_in = {b, 8'h00};
               else if (hpos_ff == HPW'(1)) cls_in = {cls_ff[15:8], b};
               else if (hpos_ff == HPW'(2)) typ_in = b;
               else if (hpos_ff == HPW'(4)) len_in = {b, 8'h00};
               else if (hpos_ff == HPW'(5)) len_in = {len_ff[15:8], b};
               if (hpos_ff >= HPW'(HEADER_BYTES - 1)) begin
                  hpos_in = '0;
                  if (len_in < 16'(HEADER_BYTES)) begin
                     err = ERR_EXT_SHORT;
                  end else begin
                     dpos_in = '0;
                     acc_in  = '0;
                     ncnt_in = '0;
                     nbad_in = 1'b0;
                     if (len_in == 16'(HEADER_BYTES)) cmplt = 1'b1;
                     else phase_in = PH_DATA;
                  end
               end else begin
                  hpos_in = HPW'(hpos_ff + 1'b1);
               end
            end
            PH_DATA: begin
               acc_in = {acc_ff[23:0], b};
               if (sel_cur == SEL_NAME) begin
                  if (b < PRINT_LO || b > PRINT_HI) nbad_in = 1'b1;
                  if (ncnt_ff < NCW'(NAME_CAPACITY - 1)) begin
                     name_wr_en = 1'b1;
                     ncnt_in    = NCW'(ncnt_ff + 1'b1);
                  end
               end
               dpos_in = dpos_ff + 16'd1;
               if (dpos_in == len_ff - 16'(HEADER_BYTES)) begin
                  phase_in = PH_HEADER;
                  cmplt    = 1'b1;
               end
            end
            default: ;
         endcase

         if (cmplt) begin
            sel_new = select_of(cls_in, typ_in, iface_class_ff, index_type_ff,
                                name_type_ff, addr_type_ff);
            dlen = len_in - 16'(HEADER_BYTES);
            unique case (sel_new)
               SEL_INDEX: begin
                  if (dlen != 16'd4) err = ERR_INDEX_LEN;
                  else begin
                     cmd_c.has_ext   = 1'b1;
                     cmd_c.ext_kind  = K_INDEX;
                     cmd_c.ext_value = acc_in;
                  end
               end
               SEL_ADDR: begin
                  if (dlen != 16'd4) err = ERR_ADDR_LEN;
                  else begin
                     cmd_c.has_ext   = 1'b1;
                     cmd_c.ext_kind  = K_IPV4;
                     cmd_c.ext_value = acc_in;
                  end
               end
               SEL_NAME: begin
                  if (nbad_in) err = ERR_BAD_CHAR;
                  else if (dlen > 16'(NAME_CAPACITY - 1)) err = ERR_NAME_LONG;
                  else begin
                     cmd_c.has_ext   = 1'b1;
                     cmd_c.ext_kind  = K_NAME_END;
                     cmd_c.ext_value = 32'(ncnt_in);
                  end
               end
               default: ;
            endcase
            if (err == ERR_NONE && ecnt_ff != 16'hFFFF) ecnt_in = ecnt_ff + 16'd1;
         end

         if (err == ERR_NONE && eop && phase_in != PH_DROP) begin
            if (phase_in == PH_DATA) err = ERR_PAST_END;
            else if (ecnt_in == 16'd0) err = ERR_EMPTY;
            else begin
               cmd_c.has_tail   = 1'b1;
               cmd_c.tail_kind  = K_OK;
               cmd_c.tail_value = ecnt_in;
            end
         end
         if (err != ERR_NONE) begin
            cmd_c.has_tail  = 1'b1;
            cmd_c.tail_kind = K_ERROR;
            cmd_c.tail_code = err;
            phase_in        = PH_DROP;
         end
         if (eop) begin
            phase_in = PH_HEADER;
            hpos_in  = '0;
            dpos_in  = '0;
            acc_in   = '0;
            ncnt_in  = '0;
            nbad_in  = 1'b0;
            ecnt_in  = '0;
         end
      end
   end

   assign cmd      = cmd_c;
   assign cmd_push = accept && (cmd_c.has_ext || cmd_c.has_tail);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         hpos_ff  <= '0;
         cls_ff   <= '0;
         typ_ff   <= '0;
         len_ff   <= '0;
         dpos_ff  <= '0;
         acc_ff   <= '0;
         ncnt_ff  <= '0;
         nbad_ff  <= 1'b0;
         ecnt_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         hpos_ff  <= hpos_in;
         cls_ff   <= cls_in;
         typ_ff   <= typ_in;
         len_ff   <= len_in;
         dpos_ff  <= dpos_in;
         acc_ff   <= acc_in;
         ncnt_ff  <= ncnt_in;
         nbad_ff  <= nbad_in;
         ecnt_ff  <= ecnt_in;
      end
   end

endmodule

/* rtl/tlvp_cmd_fifo.sv */
// Short command queue between the parser front and the result back.
// Depends on tlvp_pkg.
module tlvp_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tlvp_pkg::cmd_type push_cmd,
   input  logic              pop,
   output tlvp_pkg::cmd_type head_cmd,
   output logic              full,
   output logic              empty
);
   import tlvp_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   cmd_type        entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PW:0]    count_ff, count_in;

   assign full     = (count_ff == (PW+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? PW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? PW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/tlvp_back.sv */
// Back of the TLV parser: expands commands into results and owns the name store.
// Depends on tlvp_pkg and tlvp_if.
module tlvp_back #(
   parameter int NAME_CAPACITY = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             fifo_empty,
   input  tlvp_pkg::cmd_type                head_cmd,
   output logic                             pop,
   output logic                             busy,
   input  logic                             name_wr_en,
   input  logic [$clog2(NAME_CAPACITY)-1:0] name_wr_addr,
   input  logic [7:0]                       name_wr_data,
   tlvp_rsp_if.source                       rsp_ch
);
   import tlvp_pkg::*;

   localparam int NAW = $clog2(NAME_CAPACITY);

   logic [7:0]     name_mem [NAME_CAPACITY];
   logic [7:0]     rd_data_ff;
   back_state_type state_ff, state_in;
   cmd_type        cmd_ff;
   logic [NAW-1:0] idx_ff, idx_in;
   logic           out_free, emit, emit_last, name_done;
   kind_type       emit_kind;
   logic [31:0]    emit_value;
   err_type        emit_code;
   logic           rsp_valid_ff, rsp_last_ff;
   kind_type       rsp_kind_ff;
   logic [31:0]    rsp_value_ff;
   err_type        rsp_code_ff;

   always_ff @(posedge clock) begin
      if (name_wr_en) name_mem[name_wr_addr] <= name_wr_data;
      rd_data_ff <= name_mem[idx_ff];
   end

   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign name_done = (NAW'(idx_ff + 1'b1) == NAW'(cmd_ff.ext_value));
   assign busy      = (state_ff != B_IDLE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (!fifo_empty) begin
               if (!head_cmd.has_ext) state_in = B_TAIL;
               else if (head_cmd.ext_kind != K_NAME_END) state_in = B_EXT;
               else if (head_cmd.ext_value == 32'd0) state_in = B_NAME_END;
               else state_in = B_FETCH;
            end
         end
         B_EXT, B_NAME_END: begin
            if (out_free) state_in = cmd_ff.has_tail ? B_TAIL : B_IDLE;
         end
         B_FETCH: state_in = B_CHAR;
         B_CHAR: begin
            if (out_free) state_in = name_done ? B_NAME_END : B_FETCH;
         end
         B_TAIL: begin
            if (out_free) state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   // Outputs of each state.
   always_comb begin
      pop        = 1'b0;
      emit       = 1'b0;
      emit_last  = 1'b0;
      emit_kind  = K_OK;
      emit_value = '0;
      emit_code  = ERR_NONE;
      idx_in     = idx_ff;
      unique case (state_ff)
         B_IDLE: begin
            pop    = !fifo_empty;
            idx_in = '0;
         end
         B_EXT: begin
            emit       = out_free;
            emit_kind  = cmd_ff.ext_kind;
            emit_value = cmd_ff.ext_value;
            emit_last  = !cmd_ff.has_tail;
         end
         B_CHAR: begin
            emit       = out_free;
            emit_kind  = K_CHAR;
            emit_value = {24'h0, rd_data_ff};
            if (out_free) idx_in = NAW'(idx_ff + 1'b1);
         end
         B_NAME_END: begin
            emit       = out_free;
            emit_kind  = K_NAME_END;
            emit_value = cmd_ff.ext_value;
            emit_last  = !cmd_ff.has_tail;
         end
         B_TAIL: begin
            emit       = out_free;
            emit_kind  = cmd_ff.tail_kind;
            emit_value = {16'h0, cmd_ff.tail_value};
            emit_code  = cmd_ff.tail_code;
            emit_last  = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pop) cmd_ff <= head_cmd;
      if (emit) begin
         rsp_kind_ff  <= emit_kind;
         rsp_value_ff <= emit_value;
         rsp_code_ff  <= emit_code;
         rsp_last_ff  <= emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         if (emit) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.kind        = rsp_kind_ff;
   assign rsp_ch.value       = rsp_value_ff;
   assign rsp_ch.error_code  = rsp_code_ff;
   assign rsp_ch.last_of_run = rsp_last_ff;

endmodule

/* rtl/interface_ident_tlv_parser_unit.sv */
// Top level of the interface identification TLV parser.
// Depends on tlvp_pkg, tlvp_if, tlvp_front, tlvp_cmd_fifo and tlvp_back.
//
//   Channel  Direction  Carries
//   req_ch   in         data_byte, end_of_payload (one payload byte per transaction)
//   rsp_ch   out        kind, value, error_code, last_of_run (one result per transaction)
//   csr_ch   in         index, wdata (one register write per transaction)
//
// The front classifies each accepted payload byte and, when it causes results, queues
// one command for the back. The back takes a command from the queue in its idle state,
// then delivers an index, address, name end or end-of-payload result from one state each;
// a name character passes a fetch state and then a character state, set by the registered
// read port of the name store. Reset is synchronous and clears all control state and the
// registers to their defaults. The front stalls when the command queue is full, and it
// stalls on a name data byte while the back still holds queued work.
module interface_ident_tlv_parser_unit #(
   parameter int HEADER_BYTES  = 6,
   parameter int NAME_CAPACITY = 32
) (
   input  logic       clock,
   input  logic       reset,
   tlvp_req_if.sink   req_ch,
   tlvp_rsp_if.source rsp_ch,
   tlvp_csr_if.sink   csr_ch
);
   import tlvp_pkg::*;

   localparam int NAW = $clog2(NAME_CAPACITY);

   // Commands flow from the front through the queue into the back.
   cmd_type        push_cmd, head_cmd;
   logic           cmd_push, cmd_pop, fifo_full, fifo_empty, back_busy;
   drain_stat_type drain_stat;

   // The name store lives in the back; the front writes it while parsing name data.
   logic           name_wr_en;
   logic [NAW-1:0] name_wr_addr;
   logic [7:0]     name_wr_data;

   assign drain_stat = '{fifo_full: fifo_full, fifo_empty: fifo_empty, back_busy: back_busy};

   tlvp_front #(
      .HEADER_BYTES (HEADER_BYTES),
      .NAME_CAPACITY(NAME_CAPACITY)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .csr_ch      (csr_ch),
      .drain_stat  (drain_stat),
      .cmd_push    (cmd_push),
      .cmd         (push_cmd),
      .name_wr_en  (name_wr_en),
      .name_wr_addr(name_wr_addr),
      .name_wr_data(name_wr_data)
   );

   tlvp_cmd_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .push_cmd(push_cmd),
      .pop     (cmd_pop),
      .head_cmd(head_cmd),
      .full    (fifo_full),
      .empty   (fifo_empty)
   );

   tlvp_back #(
      .NAME_CAPACITY(NAME_CAPACITY)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .fifo_empty  (fifo_empty),
      .head_cmd    (head_cmd),
      .pop         (cmd_pop),
      .busy        (back_busy),
      .name_wr_en  (name_wr_en),
      .name_wr_addr(name_wr_addr),
      .name_wr_data(name_wr_data),
      .rsp_ch      (rsp_ch)
   );

   // The queue must never be pushed while full or popped while empty.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !fifo_full) else $error("command queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !fifo_empty) else $error("command queue underflow");

   // A name byte must not overwrite the store while the back may still read it.
   a_name_write_safe: assert property (@(posedge clock) disable iff (reset)
      name_wr_en |-> (!back_busy && fifo_empty)) else $error("name store overwritten");

   // No result is presented in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid) else $error("result valid after reset");

endmodule

/* sim/tb_interface_ident_tlv_parser_unit.sv */
// Self-checking testbench for the interface identification TLV parser.
// Drives payload bytes and register writes, predicts every result and compares field by field.
// Depends on tlvp_pkg, tlvp_if and the top level interface_ident_tlv_parser_unit.
module tb_interface_ident_tlv_parser_unit;
   import tlvp_pkg::*;

   localparam int HDR = 6;
   localparam int CAP = 32;

   typedef struct {
      kind_type    kind;
      logic [31:0] value;
      err_type     code;
      logic        last;
   } result_type;

   // One row of the directed table. When has_expect is set, the single result of the
   // byte is typed in as well and checked against the predictor's view.
   typedef struct {
      logic [7:0] data;
      logic       eop;
      logic       has_expect;
      kind_type   kind;
      err_type    code;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tlvp_req_if req_ch ();
   tlvp_rsp_if rsp_ch ();
   tlvp_csr_if csr_ch ();

   interface_ident_tlv_parser_unit #(.HEADER_BYTES(HDR), .NAME_CAPACITY(CAP)) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   // Register shadow and parser state of the predictor.
   logic [15:0] cfg_class;
   logic [7:0]  cfg_index, cfg_name, cfg_addr;
   phase_type   p_phase;
   int unsigned p_hpos, p_dpos, p_ncount, p_ext_count;
   logic [15:0] p_class, p_len;
   logic [7:0]  p_type;
   logic [31:0] p_acc;
   logic        p_nbad;
   logic [7:0]  p_store [CAP];

   result_type  expected_results[$];
   int          errors = 0;
   int          results_seen = 0;
   int          items_sent = 0;
   int          payloads_sent = 0;
   bit          hold_off = 1'b0;
   bit          idle_stall = 1'b1;

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("interface_ident_tlv_parser_unit: mismatch");
      $finish;
   end

   task automatic report(input string what);
      errors++;
      $display("ERROR at %0t: %s", $realtime, what);
   endtask

   function automatic sel_type pick_target();
      if (p_class != cfg_class) return SEL_SKIP;
      if (p_type == cfg_index) return SEL_INDEX;
      if (p_type == cfg_name) return SEL_NAME;
      if (p_type == cfg_addr) return SEL_ADDR;
      return SEL_SKIP;
   endfunction

   function automatic void restart_parse();
      p_phase = PH_HEADER;
      p_hpos = 0;
      p_dpos = 0;
      p_acc = '0;
      p_ncount = 0;
      p_nbad = 1'b0;
      p_ext_count = 0;
   endfunction

   function automatic void push_result(ref result_type q[$], input kind_type k,
                                       input logic [31:0] v, input err_type c);
      result_type r;
      r.kind = k;
      r.value = v;
      r.code = c;
      r.last = 1'b0;
      q.push_back(r);
   endfunction

   // Closes the current extension, appending its results; returns an error code.
   function automatic err_type close_extension(ref result_type q[$]);
      int unsigned dlen;
      sel_type     s;
      dlen = p_len - HDR;
      s = pick_target();
      if (s == SEL_INDEX) begin
         if (dlen != 4) return ERR_INDEX_LEN;
         push_result(q, K_INDEX, p_acc, ERR_NONE);
      end else if (s == SEL_ADDR) begin
         if (dlen != 4) return ERR_ADDR_LEN;
         push_result(q, K_IPV4, p_acc, ERR_NONE);
      end else if (s == SEL_NAME) begin
         if (p_nbad) return ERR_BAD_CHAR;
         if (dlen > CAP - 1) return ERR_NAME_LONG;
         for (int i = 0; i < p_ncount; i++)
            push_result(q, K_CHAR, 32'(p_store[i]), ERR_NONE);
         push_result(q, K_NAME_END, p_ncount, ERR_NONE);
      end
      if (p_ext_count < 16'hFFFF) p_ext_count++;
      return ERR_NONE;
   endfunction

   // Predicts the results of one payload byte and appends them to expected_results.
   function automatic int predict_byte(input logic [7:0] b, input logic eop);
      result_type q[$];
      err_type e;
      e = ERR_NONE;
      if (p_phase == PH_HEADER) begin
         case (p_hpos)
            0: p_class[15:8] = b;
            1: p_class[7:0] = b;
            2: p_type = b;
            4: p_len[15:8] = b;
            5: p_len[7:0] = b;
            default: ;
         endcase
         if (p_hpos >= HDR - 1) begin
            p_hpos = 0;
            if (p_len < HDR) begin
               e = ERR_EXT_SHORT;
            end else begin
               p_dpos = 0;
               p_acc = '0;
               p_ncount = 0;
               p_nbad = 1'b0;
               if (p_len == HDR) e = close_extension(q);
               else p_phase = PH_DATA;
            end
         end else begin
            p_hpos++;
         end
      end else if (p_phase == PH_DATA) begin
         p_acc = {p_acc[23:0], b};
         if (pick_target() == SEL_NAME) begin
            if (b < PRINT_LO || b > PRINT_HI) p_nbad = 1'b1;
            if (p_ncount < CAP - 1) begin
               p_store[p_ncount] = (b == CHAR_UNDERSCORE) ? CHAR_DASH : b;
               p_ncount++;
            end
         end
         p_dpos = (p_dpos + 1) & 16'hFFFF;
         if (p_dpos == p_len - HDR) begin
            p_phase = PH_HEADER;
            e = close_extension(q);
         end
      end
      if (e == ERR_NONE && eop && p_phase != PH_DROP) begin
         if (p_phase == PH_DATA) e = ERR_PAST_END;
         else if (p_ext_count == 0) e = ERR_EMPTY;
         else push_result(q, K_OK, p_ext_count, ERR_NONE);
      end
      if (e != ERR_NONE) begin
         push_result(q, K_ERROR, 0, e);
         p_phase = PH_DROP;
      end
      if (eop) restart_parse();
      if (q.size() > 0) q[q.size()-1].last = 1'b1;
      foreach (q[i]) expected_results.push_back(q[i]);
      return q.size();
   endfunction

   // Idles the input for a random number of cycles; with no gap, valid stays high so the
   // next byte follows back to back.
   task automatic random_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if (!idle_stall) n = 0;
      if (n > 0) begin
         req_ch.valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   // Offers one payload byte and waits for its transaction; predicts at acceptance.
   // Valid is left high; the following gap or drain takes it down.
   task automatic send_byte(input logic [7:0] b, input logic eop, output int nres);
      req_ch.valid <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.end_of_payload <= eop;
      do @(posedge clock); while (!req_ch.ready);
      nres = predict_byte(b, eop);
      items_sent++;
      if (eop) payloads_sent++;
      @(negedge clock);
   endtask

   task automatic send_plain(input logic [7:0] b, input logic eop);
      int n;
      send_byte(b, eop, n);
      random_gap();
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [15:0] v);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.wdata <= v;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         CSR_IFACE_CLASS: cfg_class = v;
         CSR_INDEX_TYPE:  cfg_index = v[7:0];
         CSR_NAME_TYPE:   cfg_name = v[7:0];
         default:         cfg_addr = v[7:0];
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      @(negedge clock);
   endtask

   // Waits for every expected result, then lets the back drain before a register write.
   task automatic drain();
      int guard;
      guard = 0;
      req_ch.valid <= 1'b0;
      while (expected_results.size() != 0 && guard < 200_000) begin
         @(negedge clock);
         guard++;
      end
      repeat (20) @(negedge clock);
   endtask

   task automatic send_header(input logic [15:0] cls, input logic [7:0] typ,
                              input logic [15:0] len, input logic eop_last);
      send_plain(cls[15:8], 1'b0);
      send_plain(cls[7:0], 1'b0);
      send_plain(typ, 1'b0);
      send_plain(8'($urandom_range(0, 255)), 1'b0);
      send_plain(len[15:8], 1'b0);
      send_plain(len[7:0], eop_last);
   endtask

   // Builds one well-formed (mostly) extension with random content.
   task automatic send_extension(input bit final_one);
      logic [7:0]  typ;
      logic [15:0] cls;
      int          dlen, choice;
      logic [7:0]  b;
      choice = $urandom_range(0, 9);
      cls = ($urandom_range(0, 5) == 0) ? 16'($urandom) : cfg_class;
      case (choice)
         0, 1:  typ = cfg_index;
         2, 3, 4: typ = cfg_name;
         5, 6:  typ = cfg_addr;
         default: typ = 8'($urandom_range(0, 255));
      endcase
      if (typ == cfg_name && choice >= 2 && choice <= 4)
         dlen = ($urandom_range(0, 15) == 0) ? $urandom_range(31, 34) : $urandom_range(0, 8);
      else if (choice <= 6)
         dlen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 6) : 4;
      else
         dlen = $urandom_range(0, 5);
      send_header(cls, typ, 16'(dlen + HDR), final_one && dlen == 0);
      for (int i = 0; i < dlen; i++) begin
         if (typ == cfg_name && $urandom_range(0, 19) != 0)
            b = ($urandom_range(0, 4) == 0) ? CHAR_UNDERSCORE :
                8'($urandom_range(8'h20, 8'h7E));
         else
            b = 8'($urandom_range(0, 255));
         send_plain(b, final_one && i == dlen - 1);
      end
   endtask

   task automatic random_payload();
      int n, mode;
      mode = $urandom_range(0, 9);
      n = $urandom_range(1, 3);
      if (mode == 0) begin
         // Noise: random bytes with random length, possibly short or truncated.
         n = $urandom_range(1, 12);
         for (int i = 0; i < n; i++) send_plain(8'($urandom_range(0, 255)), i == n - 1);
      end else begin
         for (int i = 0; i < n; i++) send_extension(i == n - 1 && mode != 1);
         if (mode == 1) begin
            // Trailing bytes shorter than a header, or a truncated extension.
            n = $urandom_range(1, HDR + 3);
            for (int i = 0; i < n; i++) send_plain(8'($urandom_range(0, 255)), i == n - 1);
         end
      end
   endtask

   // Directed table: reset-default registers (class 0, index 1, name 2, address 3).
   row_type dir_rows[$];

   function automatic void add_row(input logic [7:0] d, input logic e,
                                   input logic he = 1'b0, input kind_type k = K_OK,
                                   input err_type c = ERR_NONE);
      row_type r;
      r.data = d; r.eop = e; r.has_expect = he; r.kind = k; r.code = c;
      dir_rows.push_back(r);
   endfunction

   initial begin
      int nres;
      cfg_class = 16'h0000; cfg_index = 8'd1; cfg_name = 8'd2; cfg_addr = 8'd3;
      p_class = '0; p_type = '0; p_len = '0;
      foreach (p_store[i]) p_store[i] = '0;
      restart_parse();
      req_ch.valid = 1'b0; req_ch.data_byte = '0; req_ch.end_of_payload = 1'b0;
      csr_ch.valid = 1'b0; csr_ch.index = CSR_IFACE_CLASS; csr_ch.wdata = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // An empty payload right after reset.
      add_row(8'hFF, 1'b1, 1'b1, K_ERROR, ERR_EMPTY);
      // A header with length below the header size.
      add_row(8'h00, 1'b0); add_row(8'h00, 1'b0); add_row(8'h01, 1'b0);
      add_row(8'h00, 1'b0); add_row(8'h00, 1'b0);
      add_row(8'h05, 1'b0, 1'b1, K_ERROR, ERR_EXT_SHORT);
      add_row(8'hAA, 1'b1);
      // An index extension of class 0, value 0xFFFFFFFF, closing the payload.
      add_row(8'h00, 1'b0); add_row(8'h00, 1'b0); add_row(8'h01, 1'b0);
      add_row(8'hFF, 1'b0); add_row(8'h00, 1'b0); add_row(8'h0A, 1'b0);
      add_row(8'hFF, 1'b0); add_row(8'hFF, 1'b0); add_row(8'hFF, 1'b0);
      add_row(8'hFF, 1'b1);
      // A header whose length runs past the payload end on its last byte.
      add_row(8'hFF, 1'b0); add_row(8'hFF, 1'b0); add_row(8'h02, 1'b0);
      add_row(8'h00, 1'b0); add_row(8'hFF, 1'b0);
      add_row(8'hFF, 1'b1, 1'b1, K_ERROR, ERR_PAST_END);

      foreach (dir_rows[i]) begin
         send_byte(dir_rows[i].data, dir_rows[i].eop, nres);
         if (dir_rows[i].has_expect) begin
            result_type r;
            r = expected_results[expected_results.size()-1];
            if (nres != 1 || r.kind != dir_rows[i].kind || r.code != dir_rows[i].code)
               report($sformatf("directed row %0d: predictor disagrees with table", i));
         end
         random_gap();
      end
      drain();

      // Several register settings, the extremes included; colliding type codes too.
      for (int phase_no = 0; phase_no < 6; phase_no++) begin
         case (phase_no)
            0: begin
               write_reg(CSR_IFACE_CLASS, 16'hFFFF); write_reg(CSR_INDEX_TYPE, 16'h00FF);
               write_reg(CSR_NAME_TYPE, 16'h0000); write_reg(CSR_ADDR_TYPE, 16'h0080);
            end
            1: begin
               write_reg(CSR_IFACE_CLASS, 16'h0000); write_reg(CSR_INDEX_TYPE, 16'h0000);
               write_reg(CSR_NAME_TYPE, 16'h00FF); write_reg(CSR_ADDR_TYPE, 16'h007F);
            end
            2: begin
               // Equal type codes: index beats name beats address.
               write_reg(CSR_INDEX_TYPE, 16'h0005); write_reg(CSR_NAME_TYPE, 16'h0005);
               write_reg(CSR_ADDR_TYPE, 16'h0005);
            end
            3: begin
               write_reg(CSR_INDEX_TYPE, 16'h0011); write_reg(CSR_NAME_TYPE, 16'h0022);
               write_reg(CSR_ADDR_TYPE, 16'h0022);
            end
            default: begin
               write_reg(CSR_IFACE_CLASS, 16'($urandom));
               write_reg(CSR_INDEX_TYPE, 16'($urandom_range(0, 255)));
               write_reg(CSR_NAME_TYPE, 16'($urandom_range(0, 255)));
               write_reg(CSR_ADDR_TYPE, 16'($urandom_range(0, 255)));
            end
         endcase
         idle_stall = (phase_no != 4);
         // The long receiver hold-off happens once, in the middle of the run.
         if (phase_no == 3) hold_off = 1'b1;
         while (items_sent < 80 * (phase_no + 1) + dir_rows.size()) random_payload();
         drain();
      end

      $display("Run covered %0d payload bytes in %0d payloads, %0d results checked.",
               items_sent, payloads_sent, results_seen);
      $display("Six register settings were used, including extremes and equal type codes.");
      if (errors == 0 && expected_results.size() == 0) begin
         $display("interface_ident_tlv_parser_unit: match");
      end else begin
         $display("interface_ident_tlv_parser_unit: mismatch");
      end
      $finish;
   end

   // Receiver: random ready pattern; once, a long hold-off counted in its own process.
   initial begin
      int n;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_ch.ready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_off = 1'b0;
         end
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
         if ($urandom_range(0, 3) == 0) n = 0;
         if (n > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   end

   // Result checker: every accepted transaction meets the oldest expectation.
   always @(posedge clock) begin
      result_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            report($sformatf("unexpected result kind %0d", rsp_ch.kind));
         end else begin
            e = expected_results.pop_front();
            if (rsp_ch.kind !== e.kind || rsp_ch.value !== e.value ||
                rsp_ch.error_code !== e.code || rsp_ch.last_of_run !== e.last)
               report($sformatf("got k%0d v%h e%0d l%0d, wanted k%0d v%h e%0d l%0d",
                        rsp_ch.kind, rsp_ch.value, rsp_ch.error_code, rsp_ch.last_of_run,
                        e.kind, e.value, e.code, e.last));
         end
      end
   end

endmodule
